@@ sv/lzss_pkg.sv @@
// Shared types and constants for the LZSS stream decompressor.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package lzss_pkg;

   localparam int LZSS_WINDOW_SIZE = 4096;

   localparam int TOKENS_PER_FLAG = 8;
   localparam int MIN_MATCH       = 3;
   localparam logic [1:0] HEADER_LAST = 2'd3;

   // Class of the word at the input, as the parser sees it in its current state.
   typedef enum logic [1:0] {
      ITEM_NONE  = 2'd0,
      ITEM_LIT   = 2'd1,
      ITEM_MATCH = 2'd2
   } item_kind_type;

   typedef struct packed {
      logic accept;
      logic emit_lit;
      logic emit_copy;
      logic finish;
   } cmd_type;

   typedef struct packed {
      item_kind_type kind;
      logic          slot_free;
      logic          run_last;
   } status_type;

endpackage

`default_nettype wire

@@ sv/lzss_stream_decompressor_top.sv @@
// LZSS stream decompressor (12-bit distance, 4-bit length): top level.
// Depends on lzss_pkg, lzss_ctrl, lzss_dp and, through the datapath, lzss_ram.
`default_nettype none

// The block takes one compressed word per input handshake and produces the
// decompressed bytes on the output channel, one word per byte. Header words,
// flag words, the low byte of a match and words that arrive after out_length
// bytes have been produced are taken in the idle state alone. A literal goes
// through the accept state, then the state that loads the output register. A
// match goes through the accept state, then a read and a copy state per byte
// (up to 18 bytes), since each copied byte is read from the history RAM through
// its registered read port and written back before the next read, which keeps
// overlapping copies correct. Output back-pressure holds the literal and copy
// states. Only the output register parts the two channels; a new word is taken
// once the previous word's bytes are all in the output register. The history
// RAM is not cleared after reset, so there is no start-up delay.
module lzss_stream_decompressor_top #(
   parameter int WINDOW_SIZE = lzss_pkg::LZSS_WINDOW_SIZE
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run,
   output logic             rsp_stream_done
);
   import lzss_pkg::*;

   cmd_type    cmd;
   status_type st;

   lzss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   lzss_dp #(
      .WINDOW_SIZE(WINDOW_SIZE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd),
      .st              (st),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_stream_done (rsp_stream_done)
   );

   // The word that completes the stream always closes the run of its input word.
   a_done_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_last_of_run)
      else $error("stream_done without last_of_run");

   // A byte is only loaded when the output register is free to take it.
   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_lit || cmd.emit_copy) |-> st.slot_free)
      else $error("output register overwritten");

   // A word that yields output blocks further input until its bytes are out.
   a_busy_after_work: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && (st.kind == ITEM_LIT || st.kind == ITEM_MATCH) |=> !req_ready)
      else $error("input accepted during an output run");

endmodule

`default_nettype wire

@@ sv/lzss_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package needed.
`default_nettype none

module lzss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/lzss_ctrl.sv @@
// Sequencing state machine: accepts a word, then drives literal or match-copy output.
// Depends on lzss_pkg for the command and status structs.
`default_nettype none

module lzss_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire lzss_pkg::status_type st,
   output lzss_pkg::cmd_type        cmd
);
   import lzss_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LIT  = 4'b0010,
      S_READ = 4'b0100,
      S_COPY = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (st.kind)
                  ITEM_LIT:   state_in = S_LIT;
                  ITEM_MATCH: state_in = S_READ;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_LIT: begin
            if (st.slot_free) begin
               cmd.emit_lit = 1'b1;
               cmd.finish   = 1'b1;
               state_in     = S_IDLE;
            end
         end
         // Wait state while the history read lands in the RAM output register.
         S_READ: begin
            state_in = S_COPY;
         end
         S_COPY: begin
            if (st.slot_free) begin
               cmd.emit_copy = 1'b1;
               if (st.run_last) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/lzss_dp.sv @@
// Datapath: stream parser registers, output counter, history RAM and output register.
// Depends on lzss_pkg and lzss_ram.
`default_nettype none

module lzss_dp #(
   parameter int WINDOW_SIZE = lzss_pkg::LZSS_WINDOW_SIZE
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [31:0]          csr_wr_data,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_last_byte,
   input  wire logic                 rsp_ready,
   input  wire lzss_pkg::cmd_type    cmd,
   output lzss_pkg::status_type      st,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last_of_run,
   output logic                      rsp_stream_done
);
   import lzss_pkg::*;

   localparam int AW = $clog2(WINDOW_SIZE);
   localparam logic [3:0] TOK_FULL = 4'(TOKENS_PER_FLAG);

   typedef enum logic [2:0] {
      PH_HEADER   = 3'b001,
      PH_TOKEN    = 3'b010,
      PH_MATCH_HI = 3'b100
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  hdr_ff, hdr_in;
   logic [3:0]  tok_ff, tok_in;
   logic [7:0]  flag_ff, flag_in;
   logic [7:0]  mlow_ff, mlow_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] out_length_ff, out_length_in;
   logic        last_pend_ff, last_pend_in;
   logic [7:0]  lit_ff, lit_in;
   logic [11:0] dist_ff, dist_in;
   logic [4:0]  rem_ff, rem_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_done_ff, rsp_done_in;

   logic          below_len;
   logic [31:0]   count_inc;
   logic          at_end;
   logic          emit;
   logic          rearm;
   logic          tok_full;
   logic [7:0]    emit_byte;
   logic [7:0]    ram_rd_data;
   logic [AW-1:0] ram_rd_addr;
   item_kind_type kind;

   assign below_len = (count_ff < out_length_ff);
   assign count_inc = count_ff + 32'd1;
   assign at_end    = (count_inc == out_length_ff);
   assign emit      = cmd.emit_lit | cmd.emit_copy;
   assign tok_full  = (tok_ff >= TOK_FULL);
   assign emit_byte = cmd.emit_copy ? ram_rd_data : lit_ff;

   // Source of a copied byte is distance plus one bytes behind the next output position.
   assign ram_rd_addr = count_ff[AW-1:0] - AW'(dist_ff) - AW'(1);

   lzss_ram #(
      .WIDTH(8),
      .DEPTH(WINDOW_SIZE)
   ) u_history (
      .clock   (clock),
      .wr_en   (emit),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (emit_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      kind = ITEM_NONE;
      if (phase_ff != PH_HEADER && below_len) begin
         if (phase_ff == PH_MATCH_HI) begin
            kind = ITEM_MATCH;
         end else if (!tok_full && !flag_ff[tok_ff[2:0]]) begin
            kind = ITEM_LIT;
         end
      end
   end

   assign st.kind      = kind;
   assign st.slot_free = !rsp_valid_ff || rsp_ready;
   assign st.run_last  = (rem_ff == 5'd1) || at_end;

   always_comb begin
      phase_in      = phase_ff;
      hdr_in        = hdr_ff;
      tok_in        = tok_ff;
      flag_in       = flag_ff;
      mlow_in       = mlow_ff;
      count_in      = count_ff;
      out_length_in = out_length_ff;
      last_pend_in  = last_pend_ff;
      lit_in        = lit_ff;
      dist_in       = dist_ff;
      rem_in        = rem_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rearm         = 1'b0;

      if (csr_wr_en) begin
         out_length_in = csr_wr_data;
      end

      if (cmd.accept) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hdr_ff == HEADER_LAST) begin
                  hdr_in   = 2'd0;
                  phase_in = PH_TOKEN;
               end else begin
                  hdr_in = hdr_ff + 2'd1;
               end
            end
            PH_MATCH_HI: begin
               if (below_len) begin
                  dist_in  = {req_data_byte, mlow_ff[7:4]};
                  rem_in   = {1'b0, mlow_ff[3:0]} + 5'(MIN_MATCH);
                  tok_in   = tok_ff + 4'd1;
                  phase_in = PH_TOKEN;
               end
            end
            PH_TOKEN: begin
               if (below_len) begin
                  if (tok_full) begin
                     flag_in = req_data_byte;
                     tok_in  = 4'd0;
                  end else if (flag_ff[tok_ff[2:0]]) begin
                     mlow_in  = req_data_byte;
                     phase_in = PH_MATCH_HI;
                  end else begin
                     lit_in = req_data_byte;
                     tok_in = tok_ff + 4'd1;
                  end
               end
            end
            default: phase_in = PH_HEADER;
         endcase
         // A final word that produces output rearms only after its run is out.
         if (req_last_byte) begin
            if (kind == ITEM_NONE) begin
               rearm = 1'b1;
            end else begin
               last_pend_in = 1'b1;
            end
         end
      end

      if (emit) begin
         count_in     = count_inc;
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = cmd.emit_lit | st.run_last;
         rsp_done_in  = at_end;
         if (cmd.emit_copy) begin
            rem_in = rem_ff - 5'd1;
         end
      end

      if (cmd.finish && last_pend_ff) begin
         rearm        = 1'b1;
         last_pend_in = 1'b0;
      end

      if (rearm) begin
         phase_in = PH_HEADER;
         hdr_in   = 2'd0;
         tok_in   = TOK_FULL;
         count_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         hdr_ff        <= 2'd0;
         tok_ff        <= TOK_FULL;
         flag_ff       <= 8'd0;
         mlow_ff       <= 8'd0;
         count_ff      <= 32'd0;
         out_length_ff <= 32'd0;
         last_pend_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         hdr_ff        <= hdr_in;
         tok_ff        <= tok_in;
         flag_ff       <= flag_in;
         mlow_ff       <= mlow_in;
         count_ff      <= count_in;
         out_length_ff <= out_length_in;
         last_pend_ff  <= last_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lit_ff      <= lit_in;
      dist_ff     <= dist_in;
      rem_ff      <= rem_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_stream_done = rsp_done_ff;

endmodule

`default_nettype wire
